// ===== rtl/rrff_pkg.sv =====
// shared constants, codes and types of the round-robin first-fit placer
`default_nettype none
package rrff_pkg;

   localparam int MAX_NODES   = 16;
   localparam int NODE_W      = $clog2(MAX_NODES);
   localparam int CNT_W       = $clog2(MAX_NODES + 1);
   localparam int NCOUNT_W    = 5;
   localparam int COST_W      = 16;
   localparam int FREE_W      = 20;
   localparam int NEED_W      = 24;
   localparam int REQ_W       = 16;
   localparam int SCNT_W      = 8;
   localparam int KIND_W      = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      OP_PLACE  = 1'b0,
      OP_UPDATE = 1'b1
   } op_type;

   localparam logic [KIND_W-1:0] KIND_PLACED   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_UPDATED  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CPU_COST     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MEM_COST     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BW_COST      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERHEAD_CPU = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERHEAD_MEM = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERHEAD_BW  = 3'd6;

   localparam logic [NCOUNT_W-1:0] RST_NODE_COUNT   = 5'd16;
   localparam logic [COST_W-1:0]   RST_CPU_COST     = 16'd1000;
   localparam logic [COST_W-1:0]   RST_MEM_COST     = 16'd512;
   localparam logic [COST_W-1:0]   RST_BW_COST      = 16'd100;
   localparam logic [COST_W-1:0]   RST_OVERHEAD_CPU = 16'd1200;
   localparam logic [COST_W-1:0]   RST_OVERHEAD_MEM = 16'd512;
   localparam logic [COST_W-1:0]   RST_OVERHEAD_BW  = 16'd120;
   localparam logic [FREE_W-1:0]   RST_FREE_CPU     = 20'd10000;
   localparam logic [FREE_W-1:0]   RST_FREE_MEM     = 20'd8192;
   localparam logic [FREE_W-1:0]   RST_FREE_BW      = 20'd1000;
   localparam logic [NODE_W-1:0]   RST_LAST         = NODE_W'(MAX_NODES - 1);

   typedef struct packed {
      logic [NCOUNT_W-1:0] node_count;
      logic [COST_W-1:0]   cpu_cost;
      logic [COST_W-1:0]   mem_cost;
      logic [COST_W-1:0]   bw_cost;
      logic [COST_W-1:0]   overhead_cpu;
      logic [COST_W-1:0]   overhead_mem;
      logic [COST_W-1:0]   overhead_bw;
   } cfg_type;

   typedef struct packed {
      op_type              op;
      logic [REQ_W-1:0]    requester_id;
      logic [SCNT_W-1:0]   server_count;
      logic [NODE_W-1:0]   update_node;
      logic [FREE_W-1:0]   free_cpu;
      logic [FREE_W-1:0]   free_memory;
      logic [FREE_W-1:0]   free_bandwidth;
      logic [NEED_W-1:0]   need_cpu;
      logic [NEED_W-1:0]   need_mem;
      logic [NEED_W-1:0]   need_bw;
   } item_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [REQ_W-1:0]    out_requester;
      logic [NODE_W-1:0]   chosen_node;
      logic [SCNT_W-1:0]   out_server_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_REDUCE = 3'b010,
      ST_SCAN   = 3'b100
   } back_state_type;

endpackage
`default_nettype wire

// ===== rtl/rrff_if.sv =====
// request and response channel interfaces of the placer
`default_nettype none
interface rrff_req_if;
   logic                           valid;
   logic                           ready;
   logic                           op;
   logic [rrff_pkg::REQ_W-1:0]     requester_id;
   logic [rrff_pkg::SCNT_W-1:0]    server_count;
   logic [rrff_pkg::NODE_W-1:0]    update_node;
   logic [rrff_pkg::FREE_W-1:0]    free_cpu;
   logic [rrff_pkg::FREE_W-1:0]    free_memory;
   logic [rrff_pkg::FREE_W-1:0]    free_bandwidth;

   modport source (
      output valid, op, requester_id, server_count, update_node,
             free_cpu, free_memory, free_bandwidth,
      input  ready
   );
   modport sink (
      input  valid, op, requester_id, server_count, update_node,
             free_cpu, free_memory, free_bandwidth,
      output ready
   );
endinterface

interface rrff_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [rrff_pkg::KIND_W-1:0]    kind;
   logic [rrff_pkg::REQ_W-1:0]     out_requester;
   logic [rrff_pkg::NODE_W-1:0]    chosen_node;
   logic [rrff_pkg::SCNT_W-1:0]    out_server_count;

   modport source (
      output valid, kind, out_requester, chosen_node, out_server_count,
      input  ready
   );
   modport sink (
      input  valid, kind, out_requester, chosen_node, out_server_count,
      output ready
   );
endinterface
`default_nettype wire

// ===== rtl/rrff_front.sv =====
// front end: input beat register and per-resource need computation
`default_nettype none
module rrff_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire rrff_pkg::cfg_type cfg,
   rrff_req_if.sink               req_bus,
   output rrff_pkg::item_type     push_item,
   output logic                   push_valid,
   input  wire logic              push_ready
);

   rrff_pkg::item_type stage_ff, stage_in;
   logic               stage_valid_ff, stage_valid_in;
   logic               take;

   always_comb begin
      req_bus.ready = !stage_valid_ff || push_ready;
      take          = req_bus.valid && req_bus.ready;

      stage_valid_in = stage_valid_ff && !push_ready;
      stage_in       = stage_ff;
      if (take) begin
         stage_valid_in          = 1'b1;
         stage_in.op             = rrff_pkg::op_type'(req_bus.op);
         stage_in.requester_id   = req_bus.requester_id;
         stage_in.server_count   = req_bus.server_count;
         stage_in.update_node    = req_bus.update_node;
         stage_in.free_cpu       = req_bus.free_cpu;
         stage_in.free_memory    = req_bus.free_memory;
         stage_in.free_bandwidth = req_bus.free_bandwidth;
         stage_in.need_cpu       = '0;
         stage_in.need_mem       = '0;
         stage_in.need_bw        = '0;
      end
   end

   // need = count * per-server cost + overhead, always fits in 24 bits
   always_comb begin
      push_valid        = stage_valid_ff;
      push_item         = stage_ff;
      push_item.need_cpu = rrff_pkg::NEED_W'(stage_ff.server_count)
                         * rrff_pkg::NEED_W'(cfg.cpu_cost)
                         + rrff_pkg::NEED_W'(cfg.overhead_cpu);
      push_item.need_mem = rrff_pkg::NEED_W'(stage_ff.server_count)
                         * rrff_pkg::NEED_W'(cfg.mem_cost)
                         + rrff_pkg::NEED_W'(cfg.overhead_mem);
      push_item.need_bw  = rrff_pkg::NEED_W'(stage_ff.server_count)
                         * rrff_pkg::NEED_W'(cfg.bw_cost)
                         + rrff_pkg::NEED_W'(cfg.overhead_bw);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_ff <= stage_in;
   end

endmodule
`default_nettype wire

// ===== rtl/rrff_queue.sv =====
// short queue between the front end and the scan engine
`default_nettype none
module rrff_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire rrff_pkg::item_type in_item,
   input  wire logic               in_valid,
   output logic                    in_ready,
   output rrff_pkg::item_type      out_item,
   output logic                    out_valid,
   input  wire logic               out_ready
);

   rrff_pkg::item_type              entries_ff [rrff_pkg::QUEUE_DEPTH];
   logic [rrff_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [rrff_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [rrff_pkg::QCNT_W-1:0]     count_ff, count_in;
   logic                            push, pop;

   always_comb begin
      in_ready  = count_ff != rrff_pkg::QCNT_W'(rrff_pkg::QUEUE_DEPTH);
      out_valid = count_ff != '0;
      out_item  = entries_ff[rd_ptr_ff];
      push      = in_valid && in_ready;
      pop       = out_valid && out_ready;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == rrff_pkg::QPTR_W'(rrff_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + rrff_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == rrff_pkg::QPTR_W'(rrff_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + rrff_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + rrff_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - rrff_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/rrff_back.sv =====
// scan engine: node tables, round-robin pointer and result register
`default_nettype none
module rrff_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire rrff_pkg::cfg_type  cfg,
   input  wire rrff_pkg::item_type pop_item,
   input  wire logic               pop_valid,
   output logic                    pop_ready,
   rrff_rsp_if.source              rsp_bus
);

   logic [rrff_pkg::FREE_W-1:0] cpu_tab_ff [rrff_pkg::MAX_NODES];
   logic [rrff_pkg::FREE_W-1:0] mem_tab_ff [rrff_pkg::MAX_NODES];
   logic [rrff_pkg::FREE_W-1:0] bw_tab_ff  [rrff_pkg::MAX_NODES];

   rrff_pkg::back_state_type    state_ff, state_in;
   rrff_pkg::item_type          work_ff, work_in;
   logic [rrff_pkg::CNT_W-1:0]  idx_ff, idx_in;
   logic [rrff_pkg::NODE_W-1:0] step_ff, step_in;
   logic [rrff_pkg::NODE_W-1:0] last_ff, last_in;
   rrff_pkg::rsp_type           out_ff, out_in;
   logic                        out_valid_ff, out_valid_in;

   logic [rrff_pkg::CNT_W-1:0]  active;
   logic [rrff_pkg::CNT_W-1:0]  idx_next;
   logic [rrff_pkg::NODE_W-1:0] cur_node;
   logic                        fits;
   logic                        tab_we;

   // zero nodes acts as one, more than the table holds is clamped
   always_comb begin
      if (cfg.node_count == '0) begin
         active = rrff_pkg::CNT_W'(1);
      end else if (32'(cfg.node_count) > rrff_pkg::MAX_NODES) begin
         active = rrff_pkg::CNT_W'(rrff_pkg::MAX_NODES);
      end else begin
         active = rrff_pkg::CNT_W'(cfg.node_count);
      end
   end

   always_comb begin
      cur_node = idx_ff[rrff_pkg::NODE_W-1:0];
      fits     = (rrff_pkg::NEED_W'(cpu_tab_ff[cur_node]) >= work_ff.need_cpu)
              && (rrff_pkg::NEED_W'(mem_tab_ff[cur_node]) >= work_ff.need_mem)
              && (rrff_pkg::NEED_W'(bw_tab_ff[cur_node])  >= work_ff.need_bw);
      idx_next = idx_ff + rrff_pkg::CNT_W'(1);
   end

   always_comb begin
      state_in     = state_ff;
      work_in      = work_ff;
      idx_in       = idx_ff;
      step_in      = step_ff;
      last_in      = last_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      tab_we       = 1'b0;
      pop_ready    = 1'b0;

      case (state_ff)
         rrff_pkg::ST_IDLE: begin
            if (pop_valid && (!out_valid_ff || rsp_bus.ready)) begin
               pop_ready = 1'b1;
               if (pop_item.op == rrff_pkg::OP_UPDATE) begin
                  tab_we                  = 1'b1;
                  out_in.kind             = rrff_pkg::KIND_UPDATED;
                  out_in.out_requester    = '0;
                  out_in.chosen_node      = pop_item.update_node;
                  out_in.out_server_count = '0;
                  out_valid_in            = 1'b1;
               end else begin
                  work_in  = pop_item;
                  idx_in   = rrff_pkg::CNT_W'(last_ff) + rrff_pkg::CNT_W'(1);
                  step_in  = '0;
                  state_in = rrff_pkg::ST_REDUCE;
               end
            end
         end
         // start node is (last + 1) mod active, by repeated subtraction
         rrff_pkg::ST_REDUCE: begin
            if (idx_ff >= active) begin
               idx_in = idx_ff - active;
            end else begin
               state_in = rrff_pkg::ST_SCAN;
            end
         end
         rrff_pkg::ST_SCAN: begin
            if (fits) begin
               out_in.kind             = rrff_pkg::KIND_PLACED;
               out_in.out_requester    = work_ff.requester_id;
               out_in.chosen_node      = cur_node;
               out_in.out_server_count = work_ff.server_count;
               out_valid_in            = 1'b1;
               last_in                 = cur_node;
               state_in                = rrff_pkg::ST_IDLE;
            end else if (rrff_pkg::CNT_W'(step_ff) == active - rrff_pkg::CNT_W'(1)) begin
               out_in.kind             = rrff_pkg::KIND_REJECTED;
               out_in.out_requester    = work_ff.requester_id;
               out_in.chosen_node      = '0;
               out_in.out_server_count = work_ff.server_count;
               out_valid_in            = 1'b1;
               state_in                = rrff_pkg::ST_IDLE;
            end else begin
               idx_in  = (idx_next == active) ? '0 : idx_next;
               step_in = step_ff + rrff_pkg::NODE_W'(1);
            end
         end
         default: begin
            state_in = rrff_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_bus.valid            = out_valid_ff;
      rsp_bus.kind             = out_ff.kind;
      rsp_bus.out_requester    = out_ff.out_requester;
      rsp_bus.chosen_node      = out_ff.chosen_node;
      rsp_bus.out_server_count = out_ff.out_server_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rrff_pkg::ST_IDLE;
         last_ff      <= rrff_pkg::RST_LAST;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < rrff_pkg::MAX_NODES; i++) begin
            cpu_tab_ff[i] <= rrff_pkg::RST_FREE_CPU;
            mem_tab_ff[i] <= rrff_pkg::RST_FREE_MEM;
            bw_tab_ff[i]  <= rrff_pkg::RST_FREE_BW;
         end
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         out_valid_ff <= out_valid_in;
         if (tab_we) begin
            cpu_tab_ff[pop_item.update_node] <= pop_item.free_cpu;
            mem_tab_ff[pop_item.update_node] <= pop_item.free_memory;
            bw_tab_ff[pop_item.update_node]  <= pop_item.free_bandwidth;
         end
      end
      work_ff <= work_in;
      idx_ff  <= idx_in;
      step_ff <= step_in;
      out_ff  <= out_in;
   end

endmodule
`default_nettype wire

// ===== rtl/round_robin_first_fit_placer_unit.sv =====
// Round-robin first-fit placer: picks a node with enough free resources.
// req_bus (valid/ready) carries placement requests (op 0) and resource
// updates (op 1); rsp_bus (valid/ready) returns exactly one beat per request
// beat, in order: placed, rejected or update applied.
// csr_we/csr_index/csr_wdata write the seven settings registers; write only
// while no request is in flight.
// An input beat is registered, its needs computed, and it enters a two-entry
// queue. The scan engine takes one item at a time: an update completes as it
// leaves the queue, writing the node table; a placement leaves the queue, finds
// its start node in the REDUCE state by repeated subtraction and then checks one
// node per cycle in the SCAN state, up to active nodes. One comparator set is
// stepped over the node table. An update passes the input register, the queue
// and the output register before rsp_bus.valid; a placement also passes the
// REDUCE and SCAN states.
// A stalled receiver holds the result in the output register; the queue and
// input register keep accepting until full.
// Synchronous reset sets the registers to their defaults, every node's free
// amounts to their initial values and the pointer to the last node; the
// block accepts beats in the first cycle after reset.
`default_nettype none
module round_robin_first_fit_placer_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   rrff_req_if.sink                               req_bus,
   rrff_rsp_if.source                             rsp_bus,
   input  wire logic                              csr_we,
   input  wire logic [rrff_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [rrff_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   rrff_pkg::cfg_type  cfg_ff, cfg_in;
   rrff_pkg::item_type push_item, pop_item;
   logic               push_valid, push_ready;
   logic               pop_valid, pop_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            rrff_pkg::CSR_NODE_COUNT:
               cfg_in.node_count = csr_wdata[rrff_pkg::NCOUNT_W-1:0];
            rrff_pkg::CSR_CPU_COST:     cfg_in.cpu_cost     = csr_wdata;
            rrff_pkg::CSR_MEM_COST:     cfg_in.mem_cost     = csr_wdata;
            rrff_pkg::CSR_BW_COST:      cfg_in.bw_cost      = csr_wdata;
            rrff_pkg::CSR_OVERHEAD_CPU: cfg_in.overhead_cpu = csr_wdata;
            rrff_pkg::CSR_OVERHEAD_MEM: cfg_in.overhead_mem = csr_wdata;
            rrff_pkg::CSR_OVERHEAD_BW:  cfg_in.overhead_bw  = csr_wdata;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.node_count   <= rrff_pkg::RST_NODE_COUNT;
         cfg_ff.cpu_cost     <= rrff_pkg::RST_CPU_COST;
         cfg_ff.mem_cost     <= rrff_pkg::RST_MEM_COST;
         cfg_ff.bw_cost      <= rrff_pkg::RST_BW_COST;
         cfg_ff.overhead_cpu <= rrff_pkg::RST_OVERHEAD_CPU;
         cfg_ff.overhead_mem <= rrff_pkg::RST_OVERHEAD_MEM;
         cfg_ff.overhead_bw  <= rrff_pkg::RST_OVERHEAD_BW;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rrff_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_bus    (req_bus),
      .push_item  (push_item),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   rrff_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_item   (push_item),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .out_item  (pop_item),
      .out_valid (pop_valid),
      .out_ready (pop_ready)
   );

   rrff_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_item  (pop_item),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// testbench for the round-robin first-fit placer: directed rows, then random phases
`timescale 1ns / 1ps
module tb;
   import rrff_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;
   localparam int STALL_LIMIT = 1000;
   localparam int PHASES = 8;
   localparam int PHASE_BEATS = 160;

   typedef struct packed {
      op_type              op;
      logic [REQ_W-1:0]    requester_id;
      logic [SCNT_W-1:0]   server_count;
      logic [NODE_W-1:0]   update_node;
      logic [FREE_W-1:0]   free_cpu;
      logic [FREE_W-1:0]   free_memory;
      logic [FREE_W-1:0]   free_bandwidth;
   } beat_t;

   typedef struct packed {
      bit                     is_csr;
      logic [CSR_IDX_W-1:0]   idx;
      logic [CSR_DATA_W-1:0]  data;
      beat_t                  beat;
      bit                     typed;
      rsp_type                want;
   } row_t;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   rrff_req_if req_bus ();
   rrff_rsp_if rsp_bus ();

   round_robin_first_fit_placer_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // shadow of the block: settings, node tables and round-robin pointer
   cfg_type            cfg;
   logic [FREE_W-1:0]  free_cpu_tbl [MAX_NODES];
   logic [FREE_W-1:0]  free_mem_tbl [MAX_NODES];
   logic [FREE_W-1:0]  free_bw_tbl  [MAX_NODES];
   logic [NODE_W-1:0]  last_pick;

   rsp_type outcomes_due [$];
   row_t    plan [$];
   int      mismatch_count = 0;
   int      idle_pct = 0;
   int      ready_hold = 0;
   int      stall_cycles = 0;

   function automatic int live_nodes();
      if (cfg.node_count == 0) return 1;
      if (cfg.node_count > MAX_NODES) return MAX_NODES;
      return int'(cfg.node_count);
   endfunction

   function automatic rsp_type decide_outcome(beat_t b);
      rsp_type r;
      logic [31:0] need_cpu;
      logic [31:0] need_mem;
      logic [31:0] need_bw;
      int n;
      int idx;
      r = '0;
      if (b.op == OP_UPDATE) begin
         free_cpu_tbl[b.update_node] = b.free_cpu;
         free_mem_tbl[b.update_node] = b.free_memory;
         free_bw_tbl[b.update_node] = b.free_bandwidth;
         r.kind = KIND_UPDATED;
         r.chosen_node = b.update_node;
         return r;
      end
      need_cpu = 32'(b.server_count) * 32'(cfg.cpu_cost) + 32'(cfg.overhead_cpu);
      need_mem = 32'(b.server_count) * 32'(cfg.mem_cost) + 32'(cfg.overhead_mem);
      need_bw = 32'(b.server_count) * 32'(cfg.bw_cost) + 32'(cfg.overhead_bw);
      n = live_nodes();
      r.kind = KIND_REJECTED;
      r.out_requester = b.requester_id;
      r.out_server_count = b.server_count;
      for (int i = 0; i < n; i++) begin
         // scan starts just past the pointer, even if it sits above the live range
         idx = (int'(last_pick) + 1 + i) % n;
         if (32'(free_cpu_tbl[idx]) >= need_cpu && 32'(free_mem_tbl[idx]) >= need_mem &&
             32'(free_bw_tbl[idx]) >= need_bw) begin
            r.kind = KIND_PLACED;
            r.chosen_node = NODE_W'(idx);
            last_pick = NODE_W'(idx);
            break;
         end
      end
      return r;
   endfunction

   // directed rows
   function automatic void csr_row(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      row_t r;
      r = '0;
      r.is_csr = 1'b1;
      r.idx = idx;
      r.data = data;
      plan.insert(plan.size(), r);
   endfunction

   function automatic void place_row(logic [REQ_W-1:0] req, logic [SCNT_W-1:0] cnt,
                                     bit typed = 1'b0,
                                     logic [KIND_W-1:0] kind = KIND_PLACED,
                                     logic [NODE_W-1:0] node = '0);
      row_t r;
      r = '0;
      r.beat.op = OP_PLACE;
      r.beat.requester_id = req;
      r.beat.server_count = cnt;
      r.beat.update_node = NODE_W'($urandom);
      r.typed = typed;
      r.want.kind = kind;
      r.want.out_requester = req;
      r.want.chosen_node = node;
      r.want.out_server_count = cnt;
      plan.insert(plan.size(), r);
   endfunction

   // an update echoes only its node; requester and count are junk that must read back 0
   function automatic void update_row(logic [NODE_W-1:0] node, logic [FREE_W-1:0] fc,
                                      logic [FREE_W-1:0] fm, logic [FREE_W-1:0] fb);
      row_t r;
      r = '0;
      r.beat.op = OP_UPDATE;
      r.beat.requester_id = REQ_W'($urandom);
      r.beat.server_count = SCNT_W'($urandom);
      r.beat.update_node = node;
      r.beat.free_cpu = fc;
      r.beat.free_memory = fm;
      r.beat.free_bandwidth = fb;
      r.typed = 1'b1;
      r.want.kind = KIND_UPDATED;
      r.want.chosen_node = node;
      plan.insert(plan.size(), r);
   endfunction

   function automatic logic [FREE_W-1:0] random_free();
      case ($urandom_range(9, 0))
         0:       return '0;
         1:       return '1;
         2, 3:    return FREE_W'($urandom);
         default: return FREE_W'($urandom_range(150000, 0));
      endcase
   endfunction

   function automatic logic [COST_W-1:0] random_cost(int unsigned ceiling);
      case ($urandom_range(7, 0))
         0:       return '0;
         1:       return '1;
         default: return COST_W'($urandom_range(ceiling, 0));
      endcase
   endfunction

   function automatic beat_t random_beat();
      beat_t b;
      b.op = ($urandom_range(99, 0) < 35) ? OP_UPDATE : OP_PLACE;
      b.requester_id = REQ_W'($urandom);
      b.server_count = ($urandom_range(3, 0) == 0) ? SCNT_W'($urandom)
                                                   : SCNT_W'($urandom_range(31, 0));
      b.update_node = NODE_W'($urandom);
      b.free_cpu = random_free();
      b.free_memory = random_free();
      b.free_bandwidth = random_free();
      return b;
   endfunction

   task automatic flag(string msg);
      mismatch_count++;
      if (mismatch_count <= 200) $display("mismatch at %0t: %s", $time, msg);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_NODE_COUNT:   cfg.node_count = data[NCOUNT_W-1:0];
         CSR_CPU_COST:     cfg.cpu_cost = data;
         CSR_MEM_COST:     cfg.mem_cost = data;
         CSR_BW_COST:      cfg.bw_cost = data;
         CSR_OVERHEAD_CPU: cfg.overhead_cpu = data;
         CSR_OVERHEAD_MEM: cfg.overhead_mem = data;
         CSR_OVERHEAD_BW:  cfg.overhead_bw = data;
         default: ;
      endcase
   endtask

   task automatic random_config();
      logic [CSR_DATA_W-1:0] nc;
      nc = CSR_DATA_W'($urandom);
      case ($urandom_range(5, 0))
         0:       nc[NCOUNT_W-1:0] = 5'd1;
         1:       nc[NCOUNT_W-1:0] = 5'd16;
         2:       nc[NCOUNT_W-1:0] = 5'd0;
         3:       nc[NCOUNT_W-1:0] = NCOUNT_W'($urandom_range(31, 17));
         default: nc[NCOUNT_W-1:0] = NCOUNT_W'($urandom_range(15, 2));
      endcase
      write_reg(CSR_NODE_COUNT, nc);
      write_reg(CSR_CPU_COST, random_cost(4095));
      write_reg(CSR_MEM_COST, random_cost(4095));
      write_reg(CSR_BW_COST, random_cost(4095));
      write_reg(CSR_OVERHEAD_CPU, random_cost(20000));
      write_reg(CSR_OVERHEAD_MEM, random_cost(20000));
      write_reg(CSR_OVERHEAD_BW, random_cost(20000));
      if ($urandom_range(1, 0) == 1) write_reg(CSR_SPARE, CSR_DATA_W'($urandom));
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (outcomes_due.size() != 0) @(posedge clock);
   endtask

   task automatic send_beat(beat_t b, bit typed, rsp_type want);
      rsp_type predicted;
      if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.op <= b.op;
      req_bus.requester_id <= b.requester_id;
      req_bus.server_count <= b.server_count;
      req_bus.update_node <= b.update_node;
      req_bus.free_cpu <= b.free_cpu;
      req_bus.free_memory <= b.free_memory;
      req_bus.free_bandwidth <= b.free_bandwidth;
      do @(posedge clock); while (!req_bus.ready);
      // predictor always runs so its state tracks typed rows too
      predicted = decide_outcome(b);
      outcomes_due.insert(outcomes_due.size(), typed ? want : predicted);
   endtask

   // result side: check each beat, stall ready in random bursts
   always @(posedge clock) begin : result_check
      rsp_type due;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         ready_hold <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (outcomes_due.size() == 0) begin
               flag($sformatf("result beat with nothing due: kind %0d node %0d",
                              rsp_bus.kind, rsp_bus.chosen_node));
            end else begin
               due = outcomes_due.pop_front();
               if (rsp_bus.kind !== due.kind)
                  flag($sformatf("kind want %0d got %0d", due.kind, rsp_bus.kind));
               if (rsp_bus.out_requester !== due.out_requester)
                  flag($sformatf("out_requester want %h got %h",
                                 due.out_requester, rsp_bus.out_requester));
               if (rsp_bus.chosen_node !== due.chosen_node)
                  flag($sformatf("chosen_node want %0d got %0d",
                                 due.chosen_node, rsp_bus.chosen_node));
               if (rsp_bus.out_server_count !== due.out_server_count)
                  flag($sformatf("out_server_count want %0d got %0d",
                                 due.out_server_count, rsp_bus.out_server_count));
            end
         end
         if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            rsp_bus.ready <= 1'b0;
         end else if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
            ready_hold <= $urandom_range(3, 0);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      bit in_csr;
      rsp_type none;
      none = '0;
      in_csr = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      rsp_bus.ready = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.op = OP_PLACE;
      req_bus.requester_id = '0;
      req_bus.server_count = '0;
      req_bus.update_node = '0;
      req_bus.free_cpu = '0;
      req_bus.free_memory = '0;
      req_bus.free_bandwidth = '0;

      cfg.node_count = RST_NODE_COUNT;
      cfg.cpu_cost = RST_CPU_COST;
      cfg.mem_cost = RST_MEM_COST;
      cfg.bw_cost = RST_BW_COST;
      cfg.overhead_cpu = RST_OVERHEAD_CPU;
      cfg.overhead_mem = RST_OVERHEAD_MEM;
      cfg.overhead_bw = RST_OVERHEAD_BW;
      for (int i = 0; i < MAX_NODES; i++) begin
         free_cpu_tbl[i] = RST_FREE_CPU;
         free_mem_tbl[i] = RST_FREE_MEM;
         free_bw_tbl[i] = RST_FREE_BW;
      end
      last_pick = RST_LAST;

      // reset defaults: scan starts at node 0
      place_row(16'h0000, 8'd0, 1'b1, KIND_PLACED, 4'd0);
      place_row(16'hFFFF, 8'd8, 1'b1, KIND_PLACED, 4'd1);
      place_row(16'h1234, 8'd9, 1'b1, KIND_REJECTED);
      place_row(16'hFFFF, 8'd255, 1'b1, KIND_REJECTED);
      update_row(4'd15, '1, '1, '1);
      place_row(16'hA5A5, 8'd255);
      update_row(4'd0, '0, '0, '0);
      place_row(16'h5A5A, 8'd0);
      // zero node count acts as one node, pointer left above it
      csr_row(CSR_NODE_COUNT, 16'hFFE0);
      place_row(16'h0001, 8'd0, 1'b1, KIND_REJECTED);
      update_row(4'd0, RST_FREE_CPU, RST_FREE_MEM, RST_FREE_BW);
      place_row(16'h8000, 8'd1, 1'b1, KIND_PLACED, 4'd0);
      // node outside the live range is still stored
      update_row(4'd5, '1, '1, '1);
      csr_row(CSR_NODE_COUNT, 16'h001F);
      place_row(16'h7FFF, 8'd255);
      csr_row(CSR_CPU_COST, 16'hFFFF);
      csr_row(CSR_MEM_COST, 16'hFFFF);
      csr_row(CSR_BW_COST, 16'hFFFF);
      csr_row(CSR_OVERHEAD_CPU, 16'hFFFF);
      csr_row(CSR_OVERHEAD_MEM, 16'hFFFF);
      csr_row(CSR_OVERHEAD_BW, 16'hFFFF);
      place_row(16'h0F0F, 8'd255, 1'b1, KIND_REJECTED);
      csr_row(CSR_SPARE, 16'hFFFF);
      place_row(16'hF0F0, 8'd15);
      place_row(16'h00FF, 8'd16, 1'b1, KIND_REJECTED);
      csr_row(CSR_CPU_COST, 16'h0000);
      csr_row(CSR_MEM_COST, 16'h0000);
      csr_row(CSR_BW_COST, 16'h0000);
      csr_row(CSR_OVERHEAD_CPU, 16'h0000);
      csr_row(CSR_OVERHEAD_MEM, 16'h0000);
      csr_row(CSR_OVERHEAD_BW, 16'h0000);
      place_row(16'h3C3C, 8'd255);
      csr_row(CSR_NODE_COUNT, 16'h0001);
      place_row(16'hC3C3, 8'd200, 1'b1, KIND_PLACED, 4'd0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      idle_pct = 40;
      foreach (plan[k]) begin
         if (plan[k].is_csr) begin
            if (!in_csr) wait_drained();
            write_reg(plan[k].idx, plan[k].data);
            in_csr = 1'b1;
         end else begin
            if (in_csr) csr_we <= 1'b0;
            in_csr = 1'b0;
            send_beat(plan[k].beat, plan[k].typed, plan[k].want);
         end
      end

      // first and last phases run without any idling
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         idle_pct = (phase == 0 || phase == PHASES - 1) ? 0 : ((phase % 2) ? 25 : 50);
         random_config();
         csr_we <= 1'b0;
         repeat (PHASE_BEATS) send_beat(random_beat(), 1'b0, none);
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
